// ----- sv/wti_pkg.sv -----
// Shared constants, types and the sine table function of the wavetable oscillator.
package wti_pkg;

  localparam int TABLE_SIZE  = 512;
  localparam int FRAC_BITS   = 23;
  localparam int SAMPLE_RATE = 44100;

  localparam int SAMPLE_W  = 16;
  localparam int FREQ_W    = 15;
  localparam int INT_W     = $clog2(TABLE_SIZE);
  localparam int PHASE_W   = INT_W + FRAC_BITS;
  localparam int ROM_DEPTH = TABLE_SIZE / 2;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int HALF_RATE = SAMPLE_RATE / 2;
  localparam int CFG_STEPS = 2;
  localparam int CNT_W     = $clog2(CFG_STEPS + 1);

  localparam logic [63:0] SPAN        = 64'(TABLE_SIZE) << FRAC_BITS;
  localparam logic [63:0] INC_WHOLE   = SPAN / 64'(SAMPLE_RATE);
  localparam logic [63:0] INC_REM     = SPAN % 64'(SAMPLE_RATE);
  localparam logic [63:0] REM_SUM_MAX = INC_REM * ((64'd1 << FREQ_W) - 64'd1)
                                        + 64'(HALF_RATE);
  localparam int          REM_SUM_W   = $clog2(REM_SUM_MAX + 64'd1);
  localparam int          RCP_SHIFT   = REM_SUM_W + $clog2(SAMPLE_RATE);
  localparam logic [63:0] RCP_MULT    = ((64'd1 << RCP_SHIFT) + 64'(SAMPLE_RATE) - 64'd1)
                                        / 64'(SAMPLE_RATE);
  localparam int          RCP_W       = $clog2(RCP_MULT + 64'd1);

  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FREQ_W-1:0]          freq_t;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic sample_t rom_entry(int k);
    logic [63:0] p;
    logic [63:0] u;
    logic [1:0]  quad;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    logic [16:0] mag;
    p    = (64'(k) * 64'd2) % 64'(TABLE_SIZE);
    u    = (p << 32) / 64'(TABLE_SIZE);
    quad = u[31:30];
    t    = u & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      t = ONE_Q30 - t;
    end
    a    = (t * HALF_PI_Q30) >> 30;
    a2   = (a * a) >> 30;
    term = ONE_Q30 - a2 / 64'd110;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd72;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd42;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd20;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd6;
    s    = (a * term) >> 30;
    v    = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    mag = {1'b0, v[15:0]};
    if (quad[1]) begin
      mag = 17'd0 - mag;
    end
    return mag[SAMPLE_W-1:0];
  endfunction

endpackage

// ----- sv/wavetable_oscillator_interp_top.sv -----
// Top level of the wavetable oscillator with linear interpolation.
//
//   channel  signals                 transfer when
//   -------  ----------------------  -------------------------
//   input    push, full, tick_i      push high and full low
//   result   pop, empty, sample_o    pop high and empty low
//   config   cfg_we_i, cfg_freq..    cfg_we_i high
//
// One tick can be taken every cycle while full is low; its sample passes the phase
// queue, the lookup registers and the output queue to reach the result ports.
// A frequency write splits the increment into a whole part and a remainder part,
// rounds the remainder by a reciprocal multiply and holds full high until the sum is loaded.
// Reset clears phase and increment at once; no clearing pass is needed.
// A stalled result side fills the output queue, then the phase queue, then full.
module wavetable_oscillator_interp_top #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             tick_i,
  output logic             empty,
  input  logic             pop,
  output wti_pkg::sample_t sample_o,
  input  logic             cfg_we_i,
  input  wti_pkg::freq_t   cfg_frequency_hz_i
);
  import wti_pkg::*;

  logic                           q_push, q_full, q_empty, q_pop;
  phase_t                         q_wphase, q_rphase;
  logic                           out_push;
  sample_t                        out_sample;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt;

  wti_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .tick_i     (tick_i),
    .full_o     (full),
    .cfg_we_i   (cfg_we_i),
    .cfg_freq_i (cfg_frequency_hz_i),
    .q_push_o   (q_push),
    .q_phase_o  (q_wphase),
    .q_full_i   (q_full)
  );

  wti_fifo #(
    .WIDTH (PHASE_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wphase),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rphase),
    .empty_o (q_empty),
    .cnt_o   ()
  );

  wti_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_phase_i    (q_rphase),
    .q_pop_o      (q_pop),
    .out_cnt_i    (out_cnt),
    .out_push_o   (out_push),
    .out_sample_o (out_sample)
  );

  wti_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_sample),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (sample_o),
    .empty_o (empty),
    .cnt_o   (out_cnt)
  );

endmodule

// ----- sv/wti_fifo.sv -----
// Small register FIFO used between the pipeline parts.
module wti_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] cnt_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = !do_push ? wptr_q :
             (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    rptr_d = !do_pop ? rptr_q :
             (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/wti_front.sv -----
// Front part: tick intake, phase accumulator and phase increment computation.
module wti_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           tick_i,
  output logic           full_o,
  input  logic           cfg_we_i,
  input  wti_pkg::freq_t cfg_freq_i,
  output logic           q_push_o,
  output wti_pkg::phase_t q_phase_o,
  input  logic           q_full_i
);
  import wti_pkg::*;

  localparam int ProdW = REM_SUM_W + RCP_W;

  phase_t                 phase_q, phase_d;
  phase_t                 inc_q, inc_d;
  phase_t                 whole_q, whole_d;
  phase_t                 frac_q, frac_d;
  logic [REM_SUM_W-1:0]   rsum_q, rsum_d;
  logic [ProdW-1:0]       rcp_prod;
  logic [CNT_W-1:0]       step_cnt_q, step_cnt_d;
  logic                   busy;
  logic                   accept;

  assign busy      = (step_cnt_q != '0);
  assign full_o    = busy || q_full_i;
  assign accept    = push_i && !full_o;
  assign q_push_o  = accept && tick_i;
  assign q_phase_o = phase_q;

  assign rcp_prod = ProdW'(rsum_q) * ProdW'(RCP_MULT);

  always_comb begin
    phase_d    = q_push_o ? phase_q + inc_q : phase_q;
    inc_d      = inc_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    rsum_d     = rsum_q;
    step_cnt_d = step_cnt_q;
    if (cfg_we_i) begin
      rsum_d     = REM_SUM_W'(INC_REM) * REM_SUM_W'(cfg_freq_i) + REM_SUM_W'(HALF_RATE);
      whole_d    = PHASE_W'(INC_WHOLE) * PHASE_W'(cfg_freq_i);
      step_cnt_d = CNT_W'(CFG_STEPS);
    end else if (busy) begin
      step_cnt_d = step_cnt_q - CNT_W'(1);
      if (step_cnt_q == CNT_W'(CFG_STEPS)) begin
        frac_d = PHASE_W'(rcp_prod >> RCP_SHIFT);
      end else begin
        inc_d = whole_q + frac_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      inc_q      <= '0;
      step_cnt_q <= '0;
    end else begin
      phase_q    <= phase_d;
      inc_q      <= inc_d;
      step_cnt_q <= step_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    whole_q <= whole_d;
    frac_q  <= frac_d;
    rsum_q  <= rsum_d;
  end

endmodule

// ----- sv/wti_back.sv -----
// Back part: table lookup and linear interpolation of one phase per cycle while the output queue has room.
module wti_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  wti_pkg::phase_t                q_phase_i,
  output logic                           q_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt_i,
  output logic                           out_push_o,
  output wti_pkg::sample_t               out_sample_o
);
  import wti_pkg::*;

  localparam int OcW  = $clog2(OUT_DEPTH + 1) + 1;
  localparam int AccW = SAMPLE_W + FRAC_BITS + 2;
  localparam logic [AccW-1:0] RoundBit = AccW'(1) << (FRAC_BITS - 1);

  sample_t rom_tbl [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam sample_t Entry = rom_entry(k);
    assign rom_tbl[k] = Entry;
  end

  logic                   s1_v_q;
  sample_t                a_q, b_q;
  logic [FRAC_BITS-1:0]   alpha_q;
  logic [ROM_AW-1:0]      idx_a, idx_b;
  logic [OcW-1:0]         in_flight;
  logic signed [SAMPLE_W:0] diff;
  logic signed [AccW-1:0] prod;
  logic [AccW-1:0]        base;
  logic [AccW-1:0]        acc;

  assign in_flight = OcW'(out_cnt_i) + OcW'(s1_v_q);
  assign q_pop_o   = !q_empty_i && (in_flight < OcW'(OUT_DEPTH));
  assign idx_a     = q_phase_i[FRAC_BITS +: ROM_AW];
  assign idx_b     = idx_a + ROM_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_q     <= rom_tbl[idx_a];
      b_q     <= rom_tbl[idx_b];
      alpha_q <= q_phase_i[FRAC_BITS-1:0];
    end
  end

  assign diff = {b_q[SAMPLE_W-1], b_q} - {a_q[SAMPLE_W-1], a_q};
  assign prod = diff * $signed({1'b0, alpha_q});
  assign base = {{2{a_q[SAMPLE_W-1]}}, a_q, {FRAC_BITS{1'b0}}};
  assign acc  = base + prod + RoundBit;

  assign out_push_o   = s1_v_q;
  assign out_sample_o = acc[FRAC_BITS +: SAMPLE_W];

endmodule

// ----- verif/tb_wavetable_oscillator_interp_top.sv -----
// Testbench for the wavetable oscillator: tick stimulus, predicted samples, result checks.
`timescale 1ns / 1ps

module tb_wavetable_oscillator_interp_top;

  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          MAX_IDLE     = 11;
  localparam int          REPORT_MAX   = 10;
  localparam logic [63:0] Q30_UNIT     = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN = 64'd1686629713;
  localparam logic [63:0] PHASE_SPAN   = 64'(wti_pkg::TABLE_SIZE) << wti_pkg::FRAC_BITS;
  localparam logic [63:0] FRAC_MASK    = (64'd1 << wti_pkg::FRAC_BITS) - 64'd1;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     push;
  logic                     full;
  logic                     tick_i;
  logic                     empty;
  logic                     pop;
  wti_pkg::sample_t         sample_o;
  logic                     cfg_we_i;
  wti_pkg::freq_t           cfg_frequency_hz_i;

  wti_pkg::sample_t         sine_table [wti_pkg::TABLE_SIZE];
  wti_pkg::phase_t          phase_now;
  wti_pkg::phase_t          phase_step;
  wti_pkg::sample_t         expected_samples[$];
  bit                       sender_gaps;
  bit                       receiver_stalls;
  bit                       hold_request;
  int                       fail_count;

  wavetable_oscillator_interp_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .tick_i             (tick_i),
    .empty              (empty),
    .pop                (pop),
    .sample_o           (sample_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_frequency_hz_i (cfg_frequency_hz_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** wavetable_oscillator_interp_top: FAILED **");
    $finish;
  end

  function automatic wti_pkg::sample_t sine_point(int k);
    logic [63:0] turn;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] poly;
    logic [63:0] mag;
    logic [1:0]  quad;
    logic [15:0] m16;
    turn = ((64'(k) * 64'd2) % 64'(wti_pkg::TABLE_SIZE) << 32) / 64'(wti_pkg::TABLE_SIZE);
    quad = turn[31:30];
    frac = turn & (Q30_UNIT - 64'd1);
    if (quad[0]) begin
      frac = Q30_UNIT - frac;
    end
    x    = (frac * QUARTER_TURN) >> 30;
    x2   = (x * x) >> 30;
    poly = Q30_UNIT - x2 / 64'd110;
    poly = Q30_UNIT - ((x2 * poly) >> 30) / 64'd72;
    poly = Q30_UNIT - ((x2 * poly) >> 30) / 64'd42;
    poly = Q30_UNIT - ((x2 * poly) >> 30) / 64'd20;
    poly = Q30_UNIT - ((x2 * poly) >> 30) / 64'd6;
    mag  = ((((x * poly) >> 30) * 64'd32767) + (Q30_UNIT >> 1)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    m16 = mag[15:0];
    return quad[1] ? wti_pkg::sample_t'(16'd0 - m16) : wti_pkg::sample_t'(m16);
  endfunction

  function automatic wti_pkg::sample_t interp_sample(wti_pkg::phase_t ph);
    int     lo_idx;
    int     hi_idx;
    longint lo_val;
    longint hi_val;
    longint weight;
    longint acc;
    lo_idx = int'((64'(ph) >> wti_pkg::FRAC_BITS) % 64'(wti_pkg::TABLE_SIZE));
    hi_idx = (lo_idx + 1) % wti_pkg::TABLE_SIZE;
    weight = longint'(64'(ph) & FRAC_MASK);
    lo_val = longint'(sine_table[lo_idx]);
    hi_val = longint'(sine_table[hi_idx]);
    acc    = lo_val * (64'sd1 <<< wti_pkg::FRAC_BITS) + (hi_val - lo_val) * weight;
    acc    = (acc + (64'sd1 <<< (wti_pkg::FRAC_BITS - 1))) >>> wti_pkg::FRAC_BITS;
    return wti_pkg::sample_t'(acc[15:0]);
  endfunction

  function automatic wti_pkg::phase_t increment_for(wti_pkg::freq_t f);
    logic [63:0] num;
    num = 64'(f) * PHASE_SPAN;
    return wti_pkg::phase_t'(((num + 64'(wti_pkg::HALF_RATE)) / 64'(wti_pkg::SAMPLE_RATE))
                             % PHASE_SPAN);
  endfunction

  task automatic send_tick(bit tick_val);
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    tick_i <= tick_val;
    do @(posedge clk_i); while (full);
    if (tick_val) begin
      expected_samples.push_back(interp_sample(phase_now));
      phase_now = wti_pkg::phase_t'((64'(phase_now) + 64'(phase_step)) % PHASE_SPAN);
    end
  endtask

  task automatic settle_idle();
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frequency(wti_pkg::freq_t f);
    settle_idle();
    cfg_we_i           <= 1'b1;
    cfg_frequency_hz_i <= f;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    phase_step  = increment_for(f);
  endtask

  task automatic test_reset_state();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_tick_low();
    write_frequency(wti_pkg::freq_t'(1000));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  task automatic test_frequency_extremes();
    write_frequency(wti_pkg::freq_t'(32767));
    repeat (5) send_tick(1'b1);
    write_frequency(wti_pkg::freq_t'(22050));
    repeat (3) send_tick(1'b1);
    write_frequency(wti_pkg::freq_t'(22051));
    repeat (3) send_tick(1'b1);
    write_frequency(wti_pkg::freq_t'(1));
    repeat (3) send_tick(1'b1);
    write_frequency(wti_pkg::freq_t'(0));
    repeat (2) send_tick(1'b1);
  endtask

  task automatic test_backpressure();
    write_frequency(wti_pkg::freq_t'(12345));
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 1'b1;
    repeat (40) send_tick(1'b1);
  endtask

  task automatic test_random_tones();
    wti_pkg::freq_t f;
    for (int ph = 0; ph < 6; ph++) begin
      if ($urandom_range(0, 2) == 0) begin
        f = wti_pkg::freq_t'($urandom_range(22051, 32767));
      end else begin
        f = wti_pkg::freq_t'($urandom_range(0, 22050));
      end
      write_frequency(f);
      sender_gaps     = (ph % 3) != 0;
      receiver_stalls = (ph % 3) != 1;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'b0);
        end
        send_tick(1'b1);
      end
    end
  endtask

  initial begin
    int stall;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      stall = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_samples.size() == 0) begin
        if (fail_count < REPORT_MAX) begin
          $display("%0t: unexpected sample %0d", $realtime, sample_o);
        end
        fail_count++;
      end else begin
        if (sample_o !== expected_samples[0]) begin
          if (fail_count < REPORT_MAX) begin
            $display("%0t: sample mismatch: expected %0d, got %0d", $realtime,
                     expected_samples[0], sample_o);
          end
          fail_count++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  initial begin
    for (int k = 0; k < wti_pkg::TABLE_SIZE; k++) begin
      sine_table[k] = sine_point(k);
    end
    phase_now          = '0;
    phase_step         = '0;
    fail_count         = 0;
    sender_gaps        = 1'b1;
    receiver_stalls    = 1'b1;
    hold_request       = 1'b0;
    rst_ni             <= 1'b0;
    push               <= 1'b0;
    tick_i             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_frequency_hz_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_tick_low();
    test_frequency_extremes();
    test_backpressure();
    test_random_tones();
    settle_idle();

    if (expected_samples.size() != 0) begin
      $display("%0d expected samples never arrived", expected_samples.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** wavetable_oscillator_interp_top: PASSED **");
    end else begin
      $display("** wavetable_oscillator_interp_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/wti_pkg.sv
sv/wti_fifo.sv
sv/wti_front.sv
sv/wti_back.sv
sv/wavetable_oscillator_interp_top.sv
verif/tb_wavetable_oscillator_interp_top.sv
